FILE: rtl/tcs_pkg.sv
// Shared types and constants of the cooperative task table scheduler.
package tcs_pkg;

    localparam int MAX_TASKS_DEF = 8;

    typedef enum logic [3:0] {
        OP_REGISTER    = 4'd0,
        OP_TICK        = 4'd1,
        OP_DISPATCH    = 4'd2,
        OP_DELAY       = 4'd3,
        OP_SET_STEP    = 4'd4,
        OP_SUSPEND     = 4'd5,
        OP_RESUME      = 4'd6,
        OP_SUSPEND_ALL = 4'd7,
        OP_RESUME_ALL  = 4'd8,
        OP_DELETE      = 4'd9,
        OP_DELETE_ALL  = 4'd10
    } t_opcode;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_WAIT = 2'd1,
        ST_SUSP = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] delay;
        logic [7:0]  step;
        logic [7:0]  owner;
    } t_slot_rec;

    typedef struct packed {
        logic       ok;
        logic       called;
        logic [2:0] chosen_slot;
        logic [7:0] run_task_id;
        logic [7:0] run_step;
        logic [3:0] task_count;
    } t_result;

endpackage

FILE: rtl/tcs_if.sv
// Request and response channel interfaces of the task table scheduler.
interface tcs_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [2:0]  slot;
    logic [7:0]  task_id;
    logic [15:0] delay_ticks;
    logic [7:0]  step_value;

    modport source (output valid, output opcode, output slot, output task_id,
                    output delay_ticks, output step_value, input ready);
    modport sink (input valid, input opcode, input slot, input task_id,
                  input delay_ticks, input step_value, output ready);
endinterface

interface tcs_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic       called;
    logic [2:0] chosen_slot;
    logic [7:0] run_task_id;
    logic [7:0] run_step;
    logic [3:0] task_count;

    modport source (output valid, output ok, output called, output chosen_slot,
                    output run_task_id, output run_step, output task_count,
                    input ready);
    modport sink (input valid, input ok, input called, input chosen_slot,
                  input run_task_id, input run_step, input task_count,
                  output ready);
endinterface

FILE: rtl/cooperative_task_table_scheduler.sv
// Cooperative task table scheduler: slot table in RAM walked by a small sequencer.
// Register, delete all and refused requests need no slot read; dispatch, delay, set step,
// suspend and resume work on one slot, and tick, suspend all, resume all and delete walk
// the slots they cover, one slot per cycle through one read port. The next request can be
// accepted as soon as the result is registered, and a result still waiting on the output
// holds the sequencer. Synchronous active-low reset clears the count, cursor and current
// slot; slot data is not cleared.
module cooperative_task_table_scheduler #(
    parameter int MAX_TASKS = tcs_pkg::MAX_TASKS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tcs_req_if.sink   i_req,
    tcs_rsp_if.source o_rsp
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int XW = (CW > 3) ? CW : 3;
    localparam int RW = $bits(tcs_pkg::t_slot_rec);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_cursor;
    logic [AW-1:0]      r_current;
    tcs_pkg::t_opcode   r_op;
    logic [15:0]        r_delay;
    logic [7:0]         r_step_val;
    logic [CW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_end;
    logic               r_pend;
    logic [AW-1:0]      r_pend_addr;
    tcs_pkg::t_result   r_res;
    tcs_pkg::t_result   r_out;
    logic               r_out_vld;

    t_state             n_state;
    logic [CW-1:0]      n_count;
    logic [AW-1:0]      n_cursor;
    logic [AW-1:0]      n_current;
    tcs_pkg::t_opcode   n_op;
    logic [15:0]        n_delay;
    logic [7:0]         n_step_val;
    logic [CW-1:0]      n_rd_ptr;
    logic [CW-1:0]      n_end;
    logic               n_pend;
    logic [AW-1:0]      n_pend_addr;
    tcs_pkg::t_result   n_res;
    tcs_pkg::t_result   n_out;
    logic               n_out_vld;

    logic               w_accept;
    logic [AW-1:0]      w_pick;
    logic [AW-1:0]      w_next;
    logic               w_cur_ok;
    logic               w_sl_ok;
    logic [RW-1:0]      w_rdata;
    tcs_pkg::t_slot_rec w_rec;
    tcs_pkg::t_slot_rec w_mod;
    logic               w_mod_we;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    tcs_pkg::t_slot_rec w_wdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_pick   = (CW'(r_cursor) < r_count) ? r_cursor : '0;
    assign w_next   = ((CW'(w_pick) + CW'(1)) < r_count) ? w_pick + 1'b1 : '0;
    assign w_cur_ok = CW'(r_current) < r_count;
    assign w_sl_ok  = XW'(i_req.slot) < XW'(r_count);

    tcs_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_TASKS)
    ) u_tcs_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_rd_ptr[AW-1:0]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_rec    = tcs_pkg::t_slot_rec'(w_rdata);
        w_mod    = w_rec;
        w_mod_we = 1'b1;
        case (r_op)
            tcs_pkg::OP_TICK: begin
                if (w_rec.status == tcs_pkg::ST_WAIT && w_rec.delay != 16'd0) begin
                    w_mod.delay = w_rec.delay - 16'd1;
                end
            end
            tcs_pkg::OP_DISPATCH: begin
                if (w_rec.status == tcs_pkg::ST_WAIT && w_rec.delay == 16'd0) begin
                    w_mod.status = tcs_pkg::ST_RUN;
                end
            end
            tcs_pkg::OP_DELAY: begin
                if (w_rec.status == tcs_pkg::ST_RUN) begin
                    w_mod.status = tcs_pkg::ST_WAIT;
                    w_mod.delay  = r_delay;
                    w_mod.step   = r_step_val;
                end else begin
                    w_mod_we = 1'b0;
                end
            end
            tcs_pkg::OP_SET_STEP: begin
                w_mod.step = r_step_val;
            end
            tcs_pkg::OP_SUSPEND, tcs_pkg::OP_SUSPEND_ALL: begin
                w_mod.status = tcs_pkg::ST_SUSP;
            end
            tcs_pkg::OP_RESUME, tcs_pkg::OP_RESUME_ALL: begin
                w_mod.status = tcs_pkg::ST_RUN;
            end
            tcs_pkg::OP_DELETE: begin
                w_mod = w_rec;
            end
            default: begin
                w_mod_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pend_addr;
        w_wdata = w_mod;
        if (w_accept && i_req.opcode == tcs_pkg::OP_REGISTER
                && r_count < CW'(MAX_TASKS)) begin
            w_we          = 1'b1;
            w_waddr       = r_count[AW-1:0];
            w_wdata       = '0;
            w_wdata.status = tcs_pkg::ST_RUN;
            w_wdata.owner = i_req.task_id;
        end else if (r_state == S_SWEEP && r_pend) begin
            w_we = w_mod_we;
            if (r_op == tcs_pkg::OP_DELETE) begin
                w_waddr = r_pend_addr - 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_current   = r_current;
        n_op        = r_op;
        n_delay     = r_delay;
        n_step_val  = r_step_val;
        n_rd_ptr    = r_rd_ptr;
        n_end       = r_end;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_vld   = r_out_vld;
        if (o_rsp.valid && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op             = tcs_pkg::t_opcode'(i_req.opcode);
                    n_delay          = i_req.delay_ticks;
                    n_step_val       = i_req.step_value;
                    n_res            = '0;
                    n_res.task_count = 4'(r_count);
                    n_state          = S_DONE;
                    case (i_req.opcode)
                        tcs_pkg::OP_REGISTER: begin
                            if (r_count < CW'(MAX_TASKS)) begin
                                n_count          = r_count + 1'b1;
                                n_res.ok         = 1'b1;
                                n_res.task_count = 4'(r_count + 1'b1);
                            end
                        end
                        tcs_pkg::OP_TICK, tcs_pkg::OP_SUSPEND_ALL,
                        tcs_pkg::OP_RESUME_ALL: begin
                            n_res.ok = 1'b1;
                            n_rd_ptr = '0;
                            n_end    = r_count;
                            n_state  = S_SWEEP;
                        end
                        tcs_pkg::OP_DISPATCH: begin
                            if (r_count != '0) begin
                                n_current         = w_pick;
                                n_cursor          = w_next;
                                n_res.ok          = 1'b1;
                                n_res.chosen_slot = 3'(w_pick);
                                n_rd_ptr          = CW'(w_pick);
                                n_end             = CW'(w_pick) + CW'(1);
                                n_state           = S_SWEEP;
                            end
                        end
                        tcs_pkg::OP_DELAY: begin
                            if (w_cur_ok) begin
                                n_rd_ptr = CW'(r_current);
                                n_end    = CW'(r_current) + CW'(1);
                                n_state  = S_SWEEP;
                            end
                        end
                        tcs_pkg::OP_SET_STEP: begin
                            if (w_cur_ok) begin
                                n_res.ok = 1'b1;
                                n_rd_ptr = CW'(r_current);
                                n_end    = CW'(r_current) + CW'(1);
                                n_state  = S_SWEEP;
                            end
                        end
                        tcs_pkg::OP_SUSPEND, tcs_pkg::OP_RESUME: begin
                            if (w_sl_ok) begin
                                n_res.ok = 1'b1;
                                n_rd_ptr = CW'(i_req.slot);
                                n_end    = CW'(i_req.slot) + CW'(1);
                                n_state  = S_SWEEP;
                            end
                        end
                        tcs_pkg::OP_DELETE: begin
                            if (w_sl_ok) begin
                                n_count          = r_count - 1'b1;
                                n_res.ok         = 1'b1;
                                n_res.task_count = 4'(r_count - 1'b1);
                                n_rd_ptr         = CW'(i_req.slot) + CW'(1);
                                n_end            = r_count;
                                n_state          = S_SWEEP;
                            end
                        end
                        tcs_pkg::OP_DELETE_ALL: begin
                            n_count          = '0;
                            n_res.ok         = 1'b1;
                            n_res.task_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                if (r_pend) begin
                    if (r_op == tcs_pkg::OP_DISPATCH
                            && w_mod.status == tcs_pkg::ST_RUN) begin
                        n_res.called      = 1'b1;
                        n_res.run_task_id = w_mod.owner;
                        n_res.run_step    = w_mod.step;
                    end
                    if (r_op == tcs_pkg::OP_DELAY) begin
                        n_res.ok = w_mod_we;
                    end
                end
                if (r_rd_ptr != r_end) begin
                    n_rd_ptr    = r_rd_ptr + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_ptr[AW-1:0];
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_current <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_current   <= n_current;
            r_op        <= n_op;
            r_delay     <= n_delay;
            r_step_val  <= n_step_val;
            r_rd_ptr    <= n_rd_ptr;
            r_end       <= n_end;
            r_pend      <= n_pend;
            r_pend_addr <= n_pend_addr;
            r_res       <= n_res;
            r_out       <= n_out;
            r_out_vld   <= n_out_vld;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.ok          = r_out.ok;
    assign o_rsp.called      = r_out.called;
    assign o_rsp.chosen_slot = r_out.chosen_slot;
    assign o_rsp.run_task_id = r_out.run_task_id;
    assign o_rsp.run_step    = r_out.run_step;
    assign o_rsp.task_count  = r_out.task_count;

endmodule

FILE: rtl/tcs_ram.sv
// Generic single write port RAM with one registered read port.
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/tcs_checker.sv
// Port-level assertions for the task table scheduler and their bind statement.
module tcs_checker #(
    parameter int MAX_TASKS = tcs_pkg::MAX_TASKS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic       i_ok,
    input logic       i_called,
    input logic [7:0] i_run_task_id,
    input logic [3:0] i_task_count
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_run_task_id)
        && $stable(i_task_count))
        else $error("response changed while stalled");

    a_called_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_called |-> i_ok)
        else $error("task called by a refused request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> 32'(i_task_count) <= MAX_TASKS)
        else $error("task count above table size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while previous request in progress");

endmodule

bind cooperative_task_table_scheduler tcs_checker #(
    .MAX_TASKS(MAX_TASKS)
) u_tcs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_ok         (o_rsp.ok),
    .i_called     (o_rsp.called),
    .i_run_task_id(o_rsp.run_task_id),
    .i_task_count (o_rsp.task_count)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the cooperative task table scheduler.
module testbench;

    localparam int SLOTS = tcs_pkg::MAX_TASKS_DEF;
    localparam int RANDOM_REQUESTS = 1550;
    localparam int DIRECTED_ROWS = 25;
    localparam int HOLD_CYCLES = 90;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;
    localparam logic [3:0] OP_UNKNOWN_LO = 4'd11;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0]       slot;
        logic [7:0]       id;
        logic [15:0]      dly;
        logic [7:0]       stp;
        logic             typed;
        tcs_pkg::t_result want;
    } t_request;

    logic clk = 1'b0;
    logic rst_n;

    tcs_req_if req_ch ();
    tcs_rsp_if rsp_ch ();

    cooperative_task_table_scheduler u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mirror of the slot table.
    tcs_pkg::t_status tbl_status [SLOTS];
    logic [15:0]      tbl_delay [SLOTS];
    logic [7:0]       tbl_step [SLOTS];
    logic [7:0]       tbl_owner [SLOTS];
    int               tbl_count = 0;
    int               scan_pos = 0;
    int               last_slot = 0;

    tcs_pkg::t_result pending_results [$];
    logic             drv_typed = 1'b0;
    tcs_pkg::t_result drv_want = '0;
    bit               hold_rsp = 1'b0;
    int               burst_left = 0;
    int               err_count = 0;
    int               n_sent = 0;
    int               n_checked = 0;
    int               n_called = 0;
    int               n_refused = 0;
    int               cycles = 0;

    function automatic tcs_pkg::t_result run_scheduler_op(logic [3:0] op, logic [2:0] sl,
                                                          logic [7:0] id, logic [15:0] dly,
                                                          logic [7:0] stp);
        tcs_pkg::t_result r;
        int n;
        int k;
        r = '0;
        n = tbl_count;
        case (op)
            tcs_pkg::OP_REGISTER: begin
                if (n < SLOTS) begin
                    tbl_status[n] = tcs_pkg::ST_RUN;
                    tbl_delay[n] = '0;
                    tbl_step[n] = '0;
                    tbl_owner[n] = id;
                    tbl_count = n + 1;
                    r.ok = 1'b1;
                end
            end
            tcs_pkg::OP_TICK: begin
                for (k = 0; k < n; k++)
                    if (tbl_status[k] == tcs_pkg::ST_WAIT && tbl_delay[k] != 0)
                        tbl_delay[k] = tbl_delay[k] - 16'd1;
                r.ok = 1'b1;
            end
            tcs_pkg::OP_DISPATCH: begin
                if (n > 0) begin
                    k = (scan_pos < n) ? scan_pos : 0;
                    last_slot = k;
                    scan_pos = (k + 1 < n) ? k + 1 : 0;
                    r.chosen_slot = k[2:0];
                    r.ok = 1'b1;
                    if (tbl_status[k] == tcs_pkg::ST_WAIT && tbl_delay[k] == 0)
                        tbl_status[k] = tcs_pkg::ST_RUN;
                    if (tbl_status[k] == tcs_pkg::ST_RUN) begin
                        r.called = 1'b1;
                        r.run_task_id = tbl_owner[k];
                        r.run_step = tbl_step[k];
                    end
                end
            end
            tcs_pkg::OP_DELAY: begin
                if (last_slot < n && tbl_status[last_slot] == tcs_pkg::ST_RUN) begin
                    tbl_delay[last_slot] = dly;
                    tbl_status[last_slot] = tcs_pkg::ST_WAIT;
                    tbl_step[last_slot] = stp;
                    r.ok = 1'b1;
                end
            end
            tcs_pkg::OP_SET_STEP: begin
                if (last_slot < n) begin
                    tbl_step[last_slot] = stp;
                    r.ok = 1'b1;
                end
            end
            tcs_pkg::OP_SUSPEND, tcs_pkg::OP_RESUME: begin
                if (sl < n) begin
                    tbl_status[sl] = (op == tcs_pkg::OP_SUSPEND) ? tcs_pkg::ST_SUSP
                                                                 : tcs_pkg::ST_RUN;
                    r.ok = 1'b1;
                end
            end
            tcs_pkg::OP_SUSPEND_ALL, tcs_pkg::OP_RESUME_ALL: begin
                for (k = 0; k < n; k++)
                    tbl_status[k] = (op == tcs_pkg::OP_SUSPEND_ALL) ? tcs_pkg::ST_SUSP
                                                                    : tcs_pkg::ST_RUN;
                r.ok = 1'b1;
            end
            tcs_pkg::OP_DELETE: begin
                if (sl < n) begin
                    for (k = sl; k + 1 < n; k++) begin
                        tbl_status[k] = tbl_status[k + 1];
                        tbl_delay[k] = tbl_delay[k + 1];
                        tbl_step[k] = tbl_step[k + 1];
                        tbl_owner[k] = tbl_owner[k + 1];
                    end
                    tbl_count = n - 1;
                    r.ok = 1'b1;
                end
            end
            tcs_pkg::OP_DELETE_ALL: begin
                tbl_count = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.task_count = tbl_count[3:0];
        return r;
    endfunction

    function automatic tcs_pkg::t_result res(logic ok, logic [3:0] cnt);
        tcs_pkg::t_result r;
        r = '0;
        r.ok = ok;
        r.task_count = cnt;
        return r;
    endfunction

    function automatic t_request mk(logic [3:0] op, logic [2:0] sl, logic [7:0] id,
                                    logic [15:0] dly, logic [7:0] stp, logic typed,
                                    tcs_pkg::t_result want);
        t_request s;
        s.op = op;
        s.slot = sl;
        s.id = id;
        s.dly = dly;
        s.stp = stp;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    // Directed table; rows with typed = 0 are checked against the mirror.
    function automatic t_request directed_row(int k);
        case (k)
            0:  return mk(tcs_pkg::OP_DISPATCH, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                          res(1'b0, 4'd0));
            1:  return mk(tcs_pkg::OP_DELAY, 3'd0, 8'h00, 16'h0005, 8'h11, 1'b1,
                          res(1'b0, 4'd0));
            2:  return mk(tcs_pkg::OP_SET_STEP, 3'd0, 8'h00, 16'h0000, 8'h22, 1'b1,
                          res(1'b0, 4'd0));
            3:  return mk(tcs_pkg::OP_SUSPEND, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                          res(1'b0, 4'd0));
            4:  return mk(tcs_pkg::OP_DELETE, 3'd7, 8'h00, 16'h0000, 8'h00, 1'b1,
                          res(1'b0, 4'd0));
            5:  return mk(OP_UNKNOWN_HI, 3'd7, 8'hFF, 16'hFFFF, 8'hFF, 1'b1,
                          res(1'b0, 4'd0));
            6:  return mk(tcs_pkg::OP_REGISTER, 3'd0, 8'hFF, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd1));
            7:  return mk(tcs_pkg::OP_REGISTER, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd2));
            8:  return mk(tcs_pkg::OP_REGISTER, 3'd0, 8'h80, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd3));
            9:  return mk(tcs_pkg::OP_REGISTER, 3'd0, 8'h01, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd4));
            10: return mk(tcs_pkg::OP_REGISTER, 3'd0, 8'h55, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd5));
            11: return mk(tcs_pkg::OP_REGISTER, 3'd0, 8'hAA, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd6));
            12: return mk(tcs_pkg::OP_REGISTER, 3'd0, 8'h7F, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd7));
            13: return mk(tcs_pkg::OP_REGISTER, 3'd0, 8'hFE, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd8));
            14: return mk(tcs_pkg::OP_REGISTER, 3'd0, 8'h33, 16'h0000, 8'h00, 1'b1,
                          res(1'b0, 4'd8));
            15: return mk(tcs_pkg::OP_DISPATCH, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                          tcs_pkg::t_result'{1'b1, 1'b1, 3'd0, 8'hFF, 8'h00, 4'd8});
            16: return mk(tcs_pkg::OP_DELAY, 3'd0, 8'h00, 16'hFFFF, 8'hFF, 1'b1,
                          res(1'b1, 4'd8));
            17: return mk(tcs_pkg::OP_SET_STEP, 3'd0, 8'h00, 16'h0000, 8'h5A, 1'b1,
                          res(1'b1, 4'd8));
            18: return mk(tcs_pkg::OP_TICK, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd8));
            19: return mk(tcs_pkg::OP_DISPATCH, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b0, '0);
            20: return mk(tcs_pkg::OP_SUSPEND_ALL, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd8));
            21: return mk(tcs_pkg::OP_RESUME_ALL, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd8));
            22: return mk(tcs_pkg::OP_DELETE, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd7));
            23: return mk(tcs_pkg::OP_DELETE_ALL, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                          res(1'b1, 4'd0));
            default: return mk(OP_UNKNOWN_LO, 3'd0, 8'h00, 16'h0000, 8'h00, 1'b1,
                               res(1'b0, 4'd0));
        endcase
    endfunction

    // Mostly well-formed traffic: every opcode, mostly short delays, dispatches most often.
    function automatic t_request random_request();
        t_request s;
        int w;
        int d;
        s = '0;
        s.id = 8'($urandom_range(0, 255));
        s.stp = 8'($urandom_range(0, 255));
        d = $urandom_range(0, 99);
        if (d < 70)
            s.dly = 16'($urandom_range(0, 4));
        else if (d < 90)
            s.dly = 16'($urandom_range(0, 40));
        else
            s.dly = 16'($urandom_range(0, 65535));
        if (tbl_count > 0 && $urandom_range(0, 99) < 85)
            s.slot = 3'($urandom_range(0, tbl_count - 1));
        else
            s.slot = 3'($urandom_range(0, 7));
        w = $urandom_range(0, 99);
        if (w < 14)
            s.op = (tbl_count < SLOTS || $urandom_range(0, 4) == 0) ? tcs_pkg::OP_REGISTER
                                                                    : tcs_pkg::OP_DISPATCH;
        else if (w < 30)
            s.op = tcs_pkg::OP_TICK;
        else if (w < 56)
            s.op = tcs_pkg::OP_DISPATCH;
        else if (w < 68)
            s.op = tcs_pkg::OP_DELAY;
        else if (w < 74)
            s.op = tcs_pkg::OP_SET_STEP;
        else if (w < 79)
            s.op = tcs_pkg::OP_SUSPEND;
        else if (w < 85)
            s.op = tcs_pkg::OP_RESUME;
        else if (w < 87)
            s.op = tcs_pkg::OP_SUSPEND_ALL;
        else if (w < 90)
            s.op = tcs_pkg::OP_RESUME_ALL;
        else if (w < 95)
            s.op = tcs_pkg::OP_DELETE;
        else if (w < 96)
            s.op = tcs_pkg::OP_DELETE_ALL;
        else
            s.op = 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        return s;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < PRINT_LIMIT)
            $display("MISMATCH: %s", msg);
        err_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(t_request s);
        req_ch.opcode = s.op;
        req_ch.slot = s.slot;
        req_ch.task_id = s.id;
        req_ch.delay_ticks = s.dly;
        req_ch.step_value = s.stp;
        drv_typed = s.typed;
        drv_want = s.want;
        req_ch.valid = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.opcode = '0;
        req_ch.slot = '0;
        req_ch.task_id = '0;
        req_ch.delay_ticks = '0;
        req_ch.step_value = '0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            send_request(directed_row(k));
            pace();
        end
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k == 400) begin
                hold_rsp = 1'b1;
                burst_left = 40;
            end
            if (k == 800) begin
                req_ch.valid = 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            send_request(random_request());
            pace();
        end
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d requests (%0d directed) and checked %0d responses.",
                 n_sent, DIRECTED_ROWS, n_checked);
        $display("Dispatch called a task %0d times; %0d requests were refused.",
                 n_called, n_refused);
        if (err_count == 0) begin
            $display("[cooperative_task_table_scheduler] OK");
        end else begin
            $display("[cooperative_task_table_scheduler] ERROR");
        end
        $finish;
    end

    // The response side stalls on its own schedule, with one long hold-off on request.
    initial begin
        int mode;
        int mode_left;
        int phase;
        bit held;
        mode = 0;
        mode_left = 0;
        phase = 0;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_rsp && !held) begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                held = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: rsp_ch.ready = 1'b1;
                    1: rsp_ch.ready = (phase % 4) != 3;
                    2: rsp_ch.ready = 1'($urandom_range(0, 1));
                    default: rsp_ch.ready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        tcs_pkg::t_result got;
        tcs_pkg::t_result want;
        if (rst_n && req_ch.valid && req_ch.ready) begin
            want = run_scheduler_op(req_ch.opcode, req_ch.slot, req_ch.task_id,
                                    req_ch.delay_ticks, req_ch.step_value);
            if (drv_typed)
                want = drv_want;
            pending_results.push_back(want);
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.ok, rsp_ch.called, rsp_ch.chosen_slot, rsp_ch.run_task_id,
                    rsp_ch.run_step, rsp_ch.task_count};
            if (pending_results.size() == 0) begin
                report_mismatch("response arrived with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch($sformatf("response %0d: ok %0b, expected %0b",
                                              n_checked, got.ok, want.ok));
                if (got.called !== want.called)
                    report_mismatch($sformatf("response %0d: called %0b, expected %0b",
                                              n_checked, got.called, want.called));
                if (got.chosen_slot !== want.chosen_slot)
                    report_mismatch($sformatf("response %0d: chosen_slot %0d, expected %0d",
                                              n_checked, got.chosen_slot, want.chosen_slot));
                if (got.run_task_id !== want.run_task_id)
                    report_mismatch($sformatf("response %0d: run_task_id %h, expected %h",
                                              n_checked, got.run_task_id, want.run_task_id));
                if (got.run_step !== want.run_step)
                    report_mismatch($sformatf("response %0d: run_step %h, expected %h",
                                              n_checked, got.run_step, want.run_step));
                if (got.task_count !== want.task_count)
                    report_mismatch($sformatf("response %0d: task_count %0d, expected %0d",
                                              n_checked, got.task_count, want.task_count));
                if (want.called)
                    n_called++;
                if (!want.ok)
                    n_refused++;
            end
            n_checked++;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d responses outstanding.",
                     cycles, pending_results.size());
            $display("[cooperative_task_table_scheduler] ERROR");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/tcs_pkg.sv
rtl/tcs_if.sv
rtl/tcs_ram.sv
rtl/cooperative_task_table_scheduler.sv
rtl/tcs_checker.sv
tb/sv/testbench.sv
